// ===== rtl/uph_pkg.sv =====
package uph_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam logic [16:0] PosMax   = 17'h1FFFF;
  localparam logic [16:0] V4Hdr    = 17'd20;
  localparam logic [16:0] V6Hdr    = 17'd40;
  localparam logic [16:0] V4AddrLo = 17'd12;
  localparam logic [16:0] V6AddrLo = 17'd8;
  localparam logic [32:0] ProtoUdp = 33'd17;

  typedef struct packed {
    logic [15:0] word;
    logic        last;
    logic [15:0] udp_length;
  } uph_entry_t;

  function automatic logic [15:0] fold_finish(input logic [32:0] s);
    logic [17:0] f1;
    logic [16:0] f2;
    logic [16:0] f3;
    logic [15:0] c;
    f1 = {2'b00, s[15:0]} + {1'b0, s[32:16]};
    f2 = {1'b0, f1[15:0]} + {15'd0, f1[17:16]};
    f3 = {1'b0, f2[15:0]} + {16'd0, f2[16]};
    c  = ~f3[15:0];
    fold_finish = (c == 16'd0) ? 16'hFFFF : c;
  endfunction

endpackage

// ===== rtl/uph_in_if.sv =====
interface uph_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        is_ipv6;
  logic [15:0] udp_length;
  logic        last;

  modport source (output valid, output data_byte, output is_ipv6, output udp_length,
                  output last, input ready);
  modport sink (input valid, input data_byte, input is_ipv6, input udp_length,
                input last, output ready);
endinterface

// ===== rtl/uph_out_if.sv =====
interface uph_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] checksum;

  modport source (output valid, output checksum, input ready);
  modport sink (input valid, input checksum, output ready);
endinterface

// ===== rtl/uph_front.sv =====
module uph_front
  import uph_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  uph_in_if.sink     in_if,
  output logic       push,
  output uph_entry_t push_entry,
  input  logic       queue_full
);

  logic [16:0] pos_r;
  logic [16:0] pos_nxt;
  logic [16:0] hdr;
  logic [16:0] lo;
  logic [16:0] seg_off;
  logic        take;

  assign in_if.ready = !queue_full;
  assign push        = in_if.valid && !queue_full;

  always_comb begin
    hdr     = in_if.is_ipv6 ? V6Hdr : V4Hdr;
    lo      = in_if.is_ipv6 ? V6AddrLo : V4AddrLo;
    seg_off = pos_r - hdr;
    take    = ((pos_r >= lo) && (pos_r < hdr)) ||
              ((pos_r >= hdr) && (seg_off < {1'b0, in_if.udp_length}));
    push_entry.word       = !take ? 16'd0 :
                            (pos_r[0] ? {8'd0, in_if.data_byte} : {in_if.data_byte, 8'd0});
    push_entry.last       = in_if.last;
    push_entry.udp_length = in_if.udp_length;
  end

  always_comb begin
    pos_nxt = pos_r;
    if (push) begin
      if (in_if.last) begin
        pos_nxt = 17'd0;
      end else if (pos_r < PosMax) begin
        pos_nxt = pos_r + 17'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 17'd0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

// ===== rtl/uph_queue.sv =====
module uph_queue
  import uph_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  uph_entry_t push_entry,
  output logic       full,
  input  logic       pop,
  output logic       not_empty,
  output uph_entry_t head
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  uph_entry_t          entries_r [DEPTH];
  logic [PW-1:0]       wr_ptr_r;
  logic [PW-1:0]       wr_ptr_nxt;
  logic [PW-1:0]       rd_ptr_r;
  logic [PW-1:0]       rd_ptr_nxt;
  logic [CW-1:0]       count_r;
  logic [CW-1:0]       count_nxt;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/uph_back.sv =====
module uph_back
  import uph_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       not_empty,
  input  uph_entry_t head,
  output logic       pop,
  uph_out_if.source  out_if
);

  logic [31:0] acc_r;
  logic [31:0] acc_nxt;
  logic [31:0] acc_add;
  logic [32:0] sum_r;
  logic [32:0] sum_nxt;
  logic        sum_valid_r;
  logic        sum_valid_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [15:0] checksum_r;
  logic [15:0] checksum_nxt;
  logic        out_advance;

  assign out_advance     = !out_valid_r || out_if.ready;
  assign pop             = not_empty && (!head.last || !sum_valid_r || out_advance);
  assign acc_add         = acc_r + {16'd0, head.word};
  assign out_if.valid    = out_valid_r;
  assign out_if.checksum = checksum_r;

  always_comb begin
    acc_nxt       = acc_r;
    sum_nxt       = sum_r;
    sum_valid_nxt = sum_valid_r;
    out_valid_nxt = out_valid_r;
    checksum_nxt  = checksum_r;
    if (out_advance) begin
      out_valid_nxt = sum_valid_r;
      checksum_nxt  = fold_finish(sum_r);
      sum_valid_nxt = 1'b0;
    end
    if (pop) begin
      if (head.last) begin
        acc_nxt       = 32'd0;
        sum_nxt       = {1'b0, acc_add} + {17'd0, head.udp_length} + ProtoUdp;
        sum_valid_nxt = 1'b1;
      end else begin
        acc_nxt = acc_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    sum_r      <= sum_nxt;
    checksum_r <= checksum_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= 32'd0;
      sum_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      sum_valid_r <= sum_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/udp_pseudo_header_checksum.sv =====
// UDP checksum engine over an IPv4 or IPv6 pseudo-header, fed one packet byte per item
// starting at the IP header. A byte is accepted every cycle while the internal queue has
// room; the only per-byte work is one 32-bit add into the running sum in the back end.
// The last byte of a packet is first written into the queue. When it is popped, the sum
// is closed with the length and protocol terms into a sum register, and the carries are
// then folded and the result complemented into the output register, which waits while
// the output is stalled. A result of zero is sent as 0xFFFF. Bytes past the UDP length
// and header bytes outside the address fields are ignored, and a packet cut short counts
// its missing bytes as zero.
module udp_pseudo_header_checksum
  import uph_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  logic      clk,
  input  logic      rst_n,
  uph_in_if.sink    in_if,
  uph_out_if.source out_if
);

  logic       push;
  uph_entry_t push_entry;
  logic       queue_full;
  logic       pop;
  logic       not_empty;
  uph_entry_t head;

  uph_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .push       (push),
    .push_entry (push_entry),
    .queue_full (queue_full)
  );

  uph_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .not_empty  (not_empty),
    .head       (head)
  );

  uph_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .not_empty (not_empty),
    .head      (head),
    .pop       (pop),
    .out_if    (out_if)
  );

endmodule

// ===== dv/udp_pseudo_header_checksum_tb.sv =====
`timescale 1ns / 1ps

module udp_pseudo_header_checksum_tb;
  import uph_pkg::*;

  localparam int unsigned UdpProtocol = 17;
  localparam int FillRandom = 0;
  localparam int FillZero = 1;
  localparam int FillOnes = 2;
  localparam int ReportLimit = 10;

  logic clk;
  logic rst_n;

  uph_in_if in_ch ();
  uph_out_if out_ch ();

  udp_pseudo_header_checksum uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  logic [15:0] expected_sums[$];
  logic [7:0] pkt_bytes[$];
  logic [16:0] byte_pos;
  logic [31:0] word_sum;
  int fail_count;
  int burst_left;
  bit gaps_on;
  int hold_cycles;

  initial begin
    clk = 1'b0;
  end

  always #2 clk = ~clk;

  function automatic logic [15:0] fold_and_invert(input logic [31:0] acc, input logic [15:0] len);
    logic [63:0] s;
    logic [15:0] c;
    s = {32'd0, acc} + {48'd0, len} + 64'(UdpProtocol);
    while (s[63:16] != 48'd0) begin
      s = {48'd0, s[15:0]} + {16'd0, s[63:16]};
    end
    c = ~s[15:0];
    return (c == 16'd0) ? 16'hFFFF : c;
  endfunction

  // Updates the running pseudo-header sum for one accepted item.
  task automatic predict_byte(input logic [7:0] d, input logic v6, input logic [15:0] len,
                              input logic lst);
    logic [16:0] hdr;
    logic [16:0] lo;
    logic take;
    hdr = v6 ? V6Hdr : V4Hdr;
    lo = v6 ? V6AddrLo : V4AddrLo;
    take = (byte_pos >= lo && byte_pos < hdr) ||
           (byte_pos >= hdr && (byte_pos - hdr) < {1'b0, len});
    if (take) begin
      word_sum = word_sum + (byte_pos[0] ? {24'd0, d} : {16'd0, d, 8'd0});
    end
    if (byte_pos != PosMax) begin
      byte_pos = byte_pos + 17'd1;
    end
    if (lst) begin
      expected_sums.push_back(fold_and_invert(word_sum, len));
      byte_pos = '0;
      word_sum = '0;
    end
  endtask

  task automatic send_byte(input logic [7:0] d, input logic v6, input logic [15:0] len,
                           input logic lst);
    int gap;
    if (gaps_on && burst_left <= 0) begin
      gap = $urandom_range(1, 6);
      burst_left = $urandom_range(1, 40);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left = burst_left - 1;
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= d;
    in_ch.is_ipv6 <= v6;
    in_ch.udp_length <= len;
    in_ch.last <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_byte(d, v6, len, lst);
  endtask

  task automatic load_packet(input int n, input int fill);
    pkt_bytes.delete();
    for (int i = 0; i < n; i++) begin
      case (fill)
        FillZero: pkt_bytes.push_back(8'h00);
        FillOnes: pkt_bytes.push_back(8'hFF);
        default: pkt_bytes.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  task automatic send_packet(input logic v6, input logic [15:0] len);
    int n;
    n = pkt_bytes.size();
    for (int i = 0; i < n; i++) begin
      send_byte(pkt_bytes[i], v6, len, i == n - 1);
    end
  endtask

  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_sums.size() != 0) @(posedge clk);
  endtask

  task automatic report_failure(input string what, input logic [15:0] exp_sum,
                                input logic [15:0] got_sum);
    fail_count = fail_count + 1;
    if (fail_count <= ReportLimit) begin
      $display("%0t: %s: expected %h, got %h", $realtime, what, exp_sum, got_sum);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_sums.size() == 0) begin
        report_failure("checksum with no packet pending", 16'hxxxx, out_ch.checksum);
      end else begin
        if (out_ch.checksum !== expected_sums[0]) begin
          report_failure("checksum mismatch", expected_sums[0], out_ch.checksum);
        end
        void'(expected_sums.pop_front());
      end
    end
  end

  initial begin : receiver
    logic [7:0] pattern;
    int span;
    out_ch.ready = 1'b0;
    pattern = 8'hFF;
    span = 0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles = hold_cycles - 1;
      end else begin
        if (span <= 0) begin
          span = $urandom_range(16, 96);
          if ($urandom_range(0, 3) == 0) begin
            pattern = 8'hFF;
          end else begin
            pattern = 8'($urandom_range(1, 255));
          end
        end
        out_ch.ready <= pattern[0];
        pattern = {pattern[0], pattern[7:1]};
        span = span - 1;
      end
    end
  end

  task automatic test_ipv4_even_length();
    load_packet(20 + 12, FillRandom);
    send_packet(1'b0, 16'd12);
  endtask

  task automatic test_ipv6_odd_length();
    load_packet(40 + 9, FillRandom);
    send_packet(1'b1, 16'd9);
  endtask

  // The words, length and protocol sum to 0xFFFF, so the complement is zero and must come out as 0xFFFF.
  task automatic test_zero_checksum();
    load_packet(20 + 8, FillZero);
    pkt_bytes[20] = 8'hFF;
    pkt_bytes[21] = 8'hE6;
    send_packet(1'b0, 16'd8);
  endtask

  task automatic test_byte_extremes();
    load_packet(40 + 8, FillOnes);
    send_packet(1'b1, 16'd8);
    load_packet(24, FillOnes);
    send_packet(1'b0, 16'hFFFF);
    load_packet(20 + 10, FillZero);
    send_packet(1'b0, 16'd10);
  endtask

  task automatic test_short_and_tiny_lengths();
    load_packet(1, FillRandom);
    send_packet(1'b1, 16'hFFFF);
    load_packet(30, FillRandom);
    send_packet(1'b0, 16'd65535);
    load_packet(20 + 2, FillRandom);
    send_packet(1'b0, 16'd0);
    load_packet(40 + 7, FillRandom);
    send_packet(1'b1, 16'd7);
  endtask

  task automatic test_trailing_bytes();
    load_packet(20 + 10 + 6, FillRandom);
    send_packet(1'b0, 16'd10);
  endtask

  task automatic test_changing_fields();
    int n;
    n = 45;
    for (int i = 0; i < n; i++) begin
      send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                16'($urandom_range(0, 30)), i == n - 1);
    end
  endtask

  // The receiver holds off while short packets keep arriving, so the block has to stall
  // its input; afterwards the sender waits for every checksum.
  task automatic test_backpressure();
    gaps_on = 1'b0;
    wait_drain();
    hold_cycles = 300;
    for (int k = 0; k < 30; k++) begin
      load_packet($urandom_range(1, 3), FillRandom);
      send_packet(1'($urandom_range(0, 1)), 16'($urandom_range(8, 20)));
    end
    wait_drain();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_packets();
    int sent;
    int kind;
    int n;
    int hdr;
    logic v6;
    logic [15:0] len;
    sent = 0;
    while (sent < 1150) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 19);
      v6 = 1'($urandom_range(0, 1));
      hdr = v6 ? 40 : 20;
      if (kind < 15) begin
        len = (kind < 13) ? 16'($urandom_range(8, 48)) : 16'($urandom_range(8, 300));
        n = hdr + int'(len);
        if ($urandom_range(0, 7) == 0) begin
          n = n + $urandom_range(1, 4);
        end
        load_packet(n, FillRandom);
        send_packet(v6, len);
      end else if (kind < 17) begin
        len = 16'($urandom_range(0, 65535));
        n = $urandom_range(1, 60);
        load_packet(n, FillRandom);
        send_packet(v6, len);
      end else if (kind < 19) begin
        len = 16'($urandom_range(0, 7));
        n = hdr + int'(len) + $urandom_range(0, 2);
        load_packet(n, FillRandom);
        send_packet(v6, len);
      end else begin
        n = $urandom_range(1, 50);
        for (int i = 0; i < n; i++) begin
          send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    16'($urandom_range(0, 65535)), i == n - 1);
        end
      end
      sent = sent + n;
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.is_ipv6 = 1'b0;
    in_ch.udp_length = '0;
    in_ch.last = 1'b0;
    byte_pos = '0;
    word_sum = '0;
    fail_count = 0;
    burst_left = 0;
    gaps_on = 1'b1;
    hold_cycles = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_ipv4_even_length();
    test_ipv6_odd_length();
    test_zero_checksum();
    test_byte_extremes();
    test_short_and_tiny_lengths();
    test_trailing_bytes();
    test_changing_fields();
    test_backpressure();
    test_random_packets();

    wait_drain();
    repeat (10) @(posedge clk);
    if (expected_sums.size() != 0) begin
      fail_count = fail_count + 1;
      $display("%0d checksums never arrived", expected_sums.size());
    end
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d failures", fail_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("Timed out with %0d checksums pending", expected_sums.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
